@@ rtl/core/odq_pkg.sv @@
// ----------------------------------------------------------------------------
// odq_pkg
// Shared types, codes and helpers for the ordered deque with delete.
// ----------------------------------------------------------------------------
package odq_pkg;

    localparam int VAL_W  = 32;
    localparam int ACT_W  = 2;
    localparam int POS_W  = 5;
    localparam int STS_W  = 2;
    localparam int OCNT_W = 6;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND  = 2'd0,
        ACT_PREPEND = 2'd1,
        ACT_DELETE  = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    typedef enum logic [STS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_DELETE
    } state_t;

    // IEEE equality on single-precision patterns: signed zeros match, NaN never does
    function automatic logic fp_equal(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        logic nan_a;
        logic nan_b;
        logic zeros;
        nan_a = (a[30:0] > 31'h7F80_0000);
        nan_b = (b[30:0] > 31'h7F80_0000);
        zeros = ((a[30:0] | b[30:0]) == 31'd0);
        return !nan_a && !nan_b && (zeros || (a == b));
    endfunction

endpackage

@@ rtl/core/odq_cell.sv @@
// ----------------------------------------------------------------------------
// odq_cell
// One storage cell: holds an entry, loads, shifts from either neighbor and
// registers a compare against the broadcast key.
// ----------------------------------------------------------------------------
module odq_cell
    import odq_pkg::*;
(
    input  logic             aclk,
    input  cell_ctrl_t       ctrl,
    input  logic [VAL_W-1:0] load_data,
    input  logic [VAL_W-1:0] prev_data,
    input  logic [VAL_W-1:0] next_data,
    input  logic [VAL_W-1:0] key,
    output logic [VAL_W-1:0] data,
    output logic             match
);

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;
    logic             match_reg;

    always_comb begin
        case (ctrl.op)
            CELL_LOAD:      data_next = load_data;
            CELL_FROM_PREV: data_next = prev_data;
            CELL_FROM_NEXT: data_next = next_data;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (ctrl.cmp_en) begin
            match_reg <= fp_equal(data_reg, key);
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ rtl/core/odq_prefix.sv @@
// ----------------------------------------------------------------------------
// odq_prefix
// Log-depth prefix OR: bit i is set when any match sits at or before cell i.
// ----------------------------------------------------------------------------
module odq_prefix #(
    parameter int DEPTH = 32
) (
    input  logic [DEPTH-1:0] match_in,
    output logic [DEPTH-1:0] seen_out
);

    localparam int LV = $clog2(DEPTH);

    logic [DEPTH-1:0] lvl [LV+1];

    always_comb begin
        lvl[0] = match_in;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
                end else begin
                    lvl[l+1][i] = lvl[l][i];
                end
            end
        end
    end

    assign seen_out = lvl[LV];

endmodule

@@ rtl/core/ordered_deque_with_delete.sv @@
// ----------------------------------------------------------------------------
// ordered_deque_with_delete
// Bounded deque of single-precision words with delete by value.
// ----------------------------------------------------------------------------
// Entries live in a row of DEPTH cells packed from the front. Append, prepend
// and read may follow back to back while results are taken. A delete first has
// the cells compare against the value at accept, then a prefix OR over the
// registered match bits picks the first hit, and that cell and every cell
// behind it pull from their right neighbor. Each word in returns
// exactly one result word. An insert into a full store is dropped with status
// full; a read beyond the count returns zero with status out of range.
module ordered_deque_with_delete
    import odq_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // action[1:0], element_value[33:2], position[38:34]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status[1:0], entry_count[7:2], read_value[39:8]
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RD_N  = (DEPTH < 32) ? DEPTH : 32;

    action_t          s_action;
    logic [VAL_W-1:0] s_value;
    logic [POS_W-1:0] s_pos;

    assign s_action = action_t'(s_tdata[1:0]);
    assign s_value  = s_tdata[33:2];
    assign s_pos    = s_tdata[38:34];

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    cell_ctrl_t       cell_ctrl [DEPTH];
    logic [VAL_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic [DEPTH-1:0] match_live;
    logic [DEPTH-1:0] seen;

    logic in_fire;
    logic full;
    logic pos_ok;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [VAL_W-1:0] prev_d;
            logic [VAL_W-1:0] next_d;
            if (g == 0) begin : g_first
                assign prev_d = s_value;
            end else begin : g_mid_p
                assign prev_d = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign next_d = cell_data[g];
            end else begin : g_mid_n
                assign next_d = cell_data[g+1];
            end
            odq_cell u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl[g]),
                .load_data (s_value),
                .prev_data (prev_d),
                .next_data (next_d),
                .key       (s_value),
                .data      (cell_data[g]),
                .match     (cell_match[g])
            );
            assign match_live[g] = cell_match[g] && (CNT_W'(g) < count_reg);
        end
    endgenerate

    odq_prefix #(.DEPTH(DEPTH)) u_prefix (
        .match_in (match_live),
        .seen_out (seen)
    );

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign pos_ok   = (CW'(s_pos) < CW'(count_reg)) && (CW'(s_pos) < CW'(DEPTH));

    always_comb begin
        logic [VAL_W-1:0] rd;
        status_t          sts;
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        sts           = ST_DONE;
        rd            = '0;
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i] = '{op: CELL_HOLD, cmp_en: 1'b0};
        end
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (s_action)
                        ACT_APPEND: begin
                            if (full) begin
                                sts = ST_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (CNT_W'(i) == count_reg) begin
                                        cell_ctrl[i].op = CELL_LOAD;
                                    end
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_PREPEND: begin
                            if (full) begin
                                sts = ST_FULL;
                            end else begin
                                cell_ctrl[0].op = CELL_LOAD;
                                for (int i = 1; i < DEPTH; i++) begin
                                    cell_ctrl[i].op = CELL_FROM_PREV;
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_DELETE: begin
                            for (int i = 0; i < DEPTH; i++) begin
                                cell_ctrl[i].cmp_en = 1'b1;
                            end
                            state_next = S_DELETE;
                        end
                        ACT_READ: begin
                            if (pos_ok) begin
                                for (int i = 0; i < RD_N; i++) begin
                                    if (s_pos == POS_W'(i)) begin
                                        rd = rd | cell_data[i];
                                    end
                                end
                            end else begin
                                sts = ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                    if (s_action != ACT_DELETE) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {rd, OCNT_W'(count_next), sts};
                    end
                end
            end
            S_DELETE: begin
                // every cell at or behind the first hit pulls from its right neighbor
                if (seen[DEPTH-1]) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (seen[i]) begin
                            cell_ctrl[i].op = CELL_FROM_NEXT;
                        end
                    end
                    count_next = count_reg - 1'b1;
                end else begin
                    sts = ST_NOMATCH;
                end
                m_tvalid_next = 1'b1;
                m_tdata_next  = {rd, OCNT_W'(count_next), sts};
                state_next    = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_delete_next: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && (s_action == ACT_DELETE) |=> (state_reg == S_DELETE) && !m_tvalid)
        else $error("delete did not enter compare phase");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == CNT_W'($past(count_reg) + 1'b1)) ||
            (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("entry count jumped");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_fire && (s_action != ACT_DELETE)) ||
            $past(state_reg == S_DELETE))
        else $error("result word without a source");

endmodule
